@@ rtl/core/enhanced_clock_page_replacer_defines.svh @@
// Assertion macros used by the page replacer controller.
`ifndef ENHANCED_CLOCK_PAGE_REPLACER_DEFINES_SVH
`define ENHANCED_CLOCK_PAGE_REPLACER_DEFINES_SVH

// Property that must hold at every rising clock edge outside reset.
`define ECPR_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Property whose consequence must hold in the cycle after the trigger.
`define ECPR_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

// Property whose consequence must hold in the same cycle as the trigger.
`define ECPR_ASSERT_SAME(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ecpr_pkg.sv @@
// Shared types and constants of the enhanced clock page replacer.
`default_nettype none

package ecpr_pkg;

  // Ring geometry.
  localparam int unsigned SLOTS     = 16;
  localparam int unsigned PAGE_BITS = 20;
  localparam int unsigned IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W     = $clog2(SLOTS + 1);

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ACCESS = 2'd1,
    OP_EVICT  = 2'd2
  } op_e;

  // Status codes of a result beat.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_ACC_CMP,
    S_EV_SCAN,
    S_EV_SHIFT,
    S_DONE
  } state_e;

  // One ring entry as stored in the entry memory.
  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 accessed;
    logic                 dirty;
  } entry_t;

  // Request from the controller to the entry memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Result of one item.
  typedef struct packed {
    logic [PAGE_BITS-1:0] victim_page;
    status_e              status;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/ecpr_ram.sv @@
// Simple dual-port entry memory with registered, write-first read data.
`default_nettype none

module ecpr_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 22
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/ecpr_ctrl.sv @@
// Sequencer that walks the entry memory for insert, access and evict.
`default_nettype none

module ecpr_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         op_i,
  input  logic [ecpr_pkg::PAGE_BITS-1:0]     page_number_i,
  input  logic                               is_write_i,
  output ecpr_pkg::mem_req_t                 mem_req_o,
  input  ecpr_pkg::entry_t                   mem_rdata_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output ecpr_pkg::res_t                     res_o
);

  import ecpr_pkg::*;

  `include "enhanced_clock_page_replacer_defines.svh"

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     hand_q, hand_d;
  logic                 hand_head_q, hand_head_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 wr_q, wr_d;
  res_t                 res_q, res_d;

  logic [CNT_W-1:0]     idx_p1;
  logic [CNT_W-1:0]     idx_p2;
  logic [CNT_W-1:0]     count_m1;
  logic                 head_norm;
  logic [IDX_W-1:0]     scan_next;
  mem_req_t             req;
  entry_t               rd;

  assign rd       = mem_rdata_i;
  assign idx_p1   = CNT_W'(idx_q) + CNT_W'(1);
  assign idx_p2   = idx_p1 + CNT_W'(1);
  assign count_m1 = count_q - CNT_W'(1);

  // A hand at or beyond the resident count stands for the head.
  assign head_norm = hand_head_q || (CNT_W'(hand_q) >= count_q);

  // The sweep wraps from the oldest entry back to the newest.
  assign scan_next = (idx_p1 >= count_q) ? '0 : idx_p1[IDX_W-1:0];

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      hand_q      <= '0;
      hand_head_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      hand_q      <= hand_d;
      hand_head_q <= hand_head_d;
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    page_q <= page_d;
    wr_q   <= wr_d;
    res_q  <= res_d;
  end

  // Next state, memory requests and results.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    hand_d      = hand_q;
    hand_head_d = hand_head_q;
    idx_d       = idx_q;
    page_d      = page_q;
    wr_d        = wr_q;
    res_d       = res_q;
    req.we      = 1'b0;
    req.waddr   = idx_q;
    req.wdata   = rd;
    req.raddr   = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          hand_head_d     = head_norm;
          page_d          = page_number_i;
          wr_d            = is_write_i;
          res_d.victim_page = '0;
          res_d.status    = STAT_OK;
          unique case (op_e'(op_i))
            OP_INSERT: begin
              if (count_q == CNT_W'(SLOTS)) begin
                res_d.status = STAT_FULL;
                state_d      = S_DONE;
              end else if (count_q == '0) begin
                state_d = S_INS_PUT;
              end else begin
                req.raddr = count_m1[IDX_W-1:0];
                idx_d     = count_m1[IDX_W-1:0];
                state_d   = S_INS_SHIFT;
              end
            end
            OP_ACCESS: begin
              if (count_q == '0) begin
                res_d.status = STAT_NOT_FOUND;
                state_d      = S_DONE;
              end else begin
                req.raddr = '0;
                idx_d     = '0;
                state_d   = S_ACC_CMP;
              end
            end
            OP_EVICT: begin
              if (count_q == '0) begin
                res_d.status = STAT_EMPTY;
                state_d      = S_DONE;
              end else begin
                req.raddr = head_norm ? '0 : hand_q;
                idx_d     = head_norm ? '0 : hand_q;
                state_d   = S_EV_SCAN;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Move each entry one place older, starting from the oldest.
      S_INS_SHIFT: begin
        req.we    = 1'b1;
        req.waddr = idx_p1[IDX_W-1:0];
        req.wdata = rd;
        if (idx_q == '0) begin
          state_d = S_INS_PUT;
        end else begin
          req.raddr = idx_q - IDX_W'(1);
          idx_d     = idx_q - IDX_W'(1);
        end
      end

      // Place the new page at the newest position.
      S_INS_PUT: begin
        req.we             = 1'b1;
        req.waddr          = '0;
        req.wdata.page     = page_q;
        req.wdata.accessed = 1'b0;
        req.wdata.dirty    = 1'b0;
        count_d            = count_q + CNT_W'(1);
        if (!hand_head_q) begin
          hand_d = hand_q + IDX_W'(1);
        end
        state_d = S_DONE;
      end

      // Search from newest to oldest for the page.
      S_ACC_CMP: begin
        if (rd.page == page_q) begin
          req.we             = 1'b1;
          req.wdata.accessed = 1'b1;
          req.wdata.dirty    = rd.dirty | wr_q;
          state_d            = S_DONE;
        end else if (idx_p1 >= count_q) begin
          res_d.status = STAT_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          req.raddr = idx_p1[IDX_W-1:0];
          idx_d     = idx_p1[IDX_W-1:0];
        end
      end

      // Clock sweep: evict a clean, unreferenced entry or age the current one.
      S_EV_SCAN: begin
        if (!rd.accessed && !rd.dirty) begin
          res_d.victim_page = rd.page;
          hand_d            = idx_q;
          if (idx_p1 < count_q) begin
            hand_head_d = 1'b0;
            req.raddr   = idx_p1[IDX_W-1:0];
            state_d     = S_EV_SHIFT;
          end else begin
            hand_head_d = 1'b1;
            count_d     = count_m1;
            state_d     = S_DONE;
          end
        end else begin
          req.we = 1'b1;
          if (rd.accessed) begin
            req.wdata.accessed = 1'b0;
          end else begin
            req.wdata.dirty = 1'b0;
          end
          req.raddr = scan_next;
          idx_d     = scan_next;
        end
      end

      // Close the gap left by the victim, one entry per cycle.
      S_EV_SHIFT: begin
        req.we = 1'b1;
        if (idx_p2 < count_q) begin
          req.raddr = idx_p2[IDX_W-1:0];
          idx_d     = idx_p1[IDX_W-1:0];
        end else begin
          count_d = count_m1;
          state_d = S_DONE;
        end
      end

      // Hand the result to the output register.
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_req_o   = req;
  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // Checks on the ring bookkeeping.
  `ECPR_ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(SLOTS), "resident count above capacity")
  `ECPR_ASSERT_SAME(a_hand_in_ring, (state_q == S_IDLE) && !hand_head_q,
    CNT_W'(hand_q) < count_q, "hand points outside the ring while idle")
  `ECPR_ASSERT_NEXT(a_insert_count, state_q == S_INS_PUT,
    count_q == $past(count_q) + CNT_W'(1), "insert did not grow the ring by one")
  `ECPR_ASSERT_SAME(a_read_in_ring,
    (state_q == S_ACC_CMP) || (state_q == S_EV_SCAN) || (state_q == S_INS_SHIFT),
    CNT_W'(idx_q) < count_q, "entry read beyond the resident count")

endmodule

`default_nettype wire

@@ rtl/core/enhanced_clock_page_replacer.sv @@
// Insert moves each resident entry one place older, then writes the new page; access reads
// from the newest entry until the page matches; evict sweeps (at most three turns of the ring),
// then shifts each entry behind the victim. The result passes through the output register;
// items are taken one at a time, and the single read port yields one entry per cycle.
// Reset empties the ring and parks the hand on the head; entry contents are not cleared.
`default_nettype none

module enhanced_clock_page_replacer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic [ecpr_pkg::PAGE_BITS-1:0] page_number_i,
  input  logic                           is_write_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ecpr_pkg::PAGE_BITS-1:0] victim_page_o,
  output logic [1:0]                     status_o
);

  import ecpr_pkg::*;

  mem_req_t             mem_req;
  entry_t               mem_rdata;
  logic                 res_valid;
  logic                 res_ready;
  res_t                 res;
  logic                 out_valid_q, out_valid_d;
  logic [PAGE_BITS-1:0] victim_q;
  logic [1:0]           status_q;

  ecpr_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  ecpr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .page_number_i (page_number_i),
    .is_write_i    (is_write_i),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Output register: takes a new result beat whenever it is empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      victim_q <= res.victim_page;
      status_q <= res.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign victim_page_o = victim_q;
  assign status_o      = status_q;

endmodule

`default_nettype wire

@@ bench/enhanced_clock_page_replacer_test.sv @@
// Self-checking testbench of the enhanced second-chance clock page replacer.
`timescale 1ns / 1ps

module enhanced_clock_page_replacer_test;
  import ecpr_pkg::*;

  localparam int unsigned HEAD_POS    = SLOTS;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOT_COUNT   = 24;

  // One command beat toward the replacer.
  typedef struct {
    op_e                  op;
    logic [PAGE_BITS-1:0] page;
    logic                 wr;
  } page_op_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  op_e                  in_op       = OP_INSERT;
  logic [PAGE_BITS-1:0] in_page     = '0;
  logic                 in_write    = 1'b0;
  logic                 out_stall   = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [PAGE_BITS-1:0] victim_page_o;
  logic [1:0]           status_o;

  // Commands waiting to be driven and outcomes waiting to be seen.
  page_op_t page_ops_q[$];
  res_t     victim_status_q[$];
  page_op_t next_op;
  res_t     due_result;

  // Shadow copy of the ring, newest entry at index zero.
  logic [PAGE_BITS-1:0] ring_page[SLOTS];
  logic                 ring_acc[SLOTS];
  logic                 ring_dirty[SLOTS];
  int unsigned          ring_count = 0;
  int unsigned          ring_hand  = HEAD_POS;

  logic [PAGE_BITS-1:0] hot_pages[HOT_COUNT];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked     = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned mismatches     = 0;

  enhanced_clock_page_replacer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .op_i          (in_op),
    .page_number_i (in_page),
    .is_write_i    (in_write),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .victim_page_o (victim_page_o),
    .status_o      (status_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Applies one command to the shadow ring and returns the outcome it must give.
  function automatic res_t apply_page_op(op_e op, logic [PAGE_BITS-1:0] page, logic wr);
    res_t        r;
    int unsigned i;
    int unsigned pos;
    int unsigned guard;
    bit          found;
    r.victim_page = '0;
    r.status      = STAT_OK;
    found         = 1'b0;
    if (ring_hand >= ring_count) ring_hand = HEAD_POS;
    case (op)
      OP_INSERT: begin
        if (ring_count >= SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          for (i = ring_count; i > 0; i--) begin
            ring_page[i]  = ring_page[i-1];
            ring_acc[i]   = ring_acc[i-1];
            ring_dirty[i] = ring_dirty[i-1];
          end
          ring_page[0]  = page;
          ring_acc[0]   = 1'b0;
          ring_dirty[0] = 1'b0;
          ring_count++;
          if (ring_hand != HEAD_POS) ring_hand++;
        end
      end
      OP_ACCESS: begin
        // The newest matching entry takes the access.
        for (i = 0; i < ring_count && !found; i++) begin
          if (ring_page[i] == page) begin
            ring_acc[i] = 1'b1;
            if (wr) ring_dirty[i] = 1'b1;
            found = 1'b1;
          end
        end
        if (!found) r.status = STAT_NOT_FOUND;
      end
      OP_EVICT: begin
        if (ring_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // Sweep from the hand, giving second chances until a clean idle entry turns up.
          pos = (ring_hand == HEAD_POS) ? 0 : ring_hand;
          for (guard = 0; guard < 4 * SLOTS + 4 && (ring_acc[pos] || ring_dirty[pos]);
               guard++) begin
            if (ring_acc[pos]) ring_acc[pos] = 1'b0;
            else ring_dirty[pos] = 1'b0;
            pos = (pos + 1 >= ring_count) ? 0 : pos + 1;
          end
          r.victim_page = ring_page[pos];
          for (i = pos; i + 1 < ring_count; i++) begin
            ring_page[i]  = ring_page[i+1];
            ring_acc[i]   = ring_acc[i+1];
            ring_dirty[i] = ring_dirty[i+1];
          end
          ring_count--;
          ring_hand = (pos < ring_count) ? pos : HEAD_POS;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_op(op_e op, logic [PAGE_BITS-1:0] page, logic wr);
    page_op_t item;
    item.op   = op;
    item.page = page;
    item.wr   = wr;
    page_ops_q.push_back(item);
  endtask

  // Random command; pages mostly come from a small hot set so that accesses hit.
  task automatic queue_random_op(int unsigned ins_w, int unsigned acc_w);
    int unsigned          pick;
    logic [PAGE_BITS-1:0] page;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 85) page = hot_pages[$urandom_range(HOT_COUNT - 1)];
    else page = PAGE_BITS'($urandom);
    if (pick < ins_w) queue_op(OP_INSERT, page, 1'($urandom_range(1)));
    else if (pick < ins_w + acc_w) queue_op(OP_ACCESS, page, 1'($urandom_range(1)));
    else queue_op(OP_EVICT, PAGE_BITS'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    while (page_ops_q.size() != 0 || in_valid || victim_status_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
  endtask

  // One traffic phase: bursts that fill, churn or drain the ring.
  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n,
                           bit long_hold);
    int unsigned sent;
    int unsigned burst;
    int unsigned mode;
    int unsigned k;
    sent = 0;
    @(negedge clk_i);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    if (long_hold) begin
      // Keep offering beats while the output is held off so the input backs up.
      hold_asked++;
      for (k = 0; k < 40; k++) queue_random_op(40, 35);
      sent = 40;
    end
    while (sent < n) begin
      burst = $urandom_range(5, 60);
      if (burst > n - sent) burst = n - sent;
      mode  = $urandom_range(2);
      for (k = 0; k < burst; k++) begin
        case (mode)
          0: queue_random_op(60, 25);
          1: queue_random_op(35, 40);
          default: queue_random_op(15, 30);
        endcase
      end
      sent += burst;
      if ($urandom_range(2) == 0) begin
        wait_drained();
      end else begin
        while (page_ops_q.size() > 3) @(negedge clk_i);
      end
    end
    wait_drained();
  endtask

  // Command driver; a stalled beat is held unchanged.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_op    <= OP_INSERT;
      in_page  <= '0;
      in_write <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o)
        victim_status_q.push_back(apply_page_op(in_op, in_page, in_write));
      if (!in_valid || !in_stall_o) begin
        if (page_ops_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_op = page_ops_q.pop_front();
          in_valid <= 1'b1;
          in_op    <= next_op.op;
          in_page  <= next_op.page;
          in_write <= next_op.wr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall, with a long hold-off counted in cycles when a phase asks for one.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker against the oldest outstanding outcome.
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && !out_stall) begin
      if (victim_status_q.size() == 0) begin
        flag_mismatch("result beat with nothing outstanding, status", 0, 32'(status_o));
      end else begin
        due_result = victim_status_q.pop_front();
        if (victim_page_o !== due_result.victim_page)
          flag_mismatch("victim_page", 32'(due_result.victim_page), 32'(victim_page_o));
        if (status_o !== due_result.status)
          flag_mismatch("status", 32'(due_result.status), 32'(status_o));
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    int unsigned k;
    int unsigned spins;
    for (k = 0; k < HOT_COUNT; k++) hot_pages[k] = PAGE_BITS'($urandom);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // Empty ring, unknown page, extreme pages, duplicates, then a full table.
    queue_op(OP_EVICT, '0, 1'b0);
    queue_op(OP_ACCESS, 20'h12345, 1'b1);
    queue_op(OP_INSERT, '0, 1'b0);
    queue_op(OP_INSERT, {PAGE_BITS{1'b1}}, 1'b1);
    queue_op(OP_ACCESS, {PAGE_BITS{1'b1}}, 1'b1);
    queue_op(OP_INSERT, '0, 1'b1);
    queue_op(OP_ACCESS, '0, 1'b1);
    queue_op(OP_EVICT, {PAGE_BITS{1'b1}}, 1'b1);
    queue_op(OP_EVICT, '0, 1'b0);
    for (k = 0; k < 15; k++)
      queue_op(OP_INSERT, PAGE_BITS'((k << 16) | (k * 20'h00111)), k[0]);
    queue_op(OP_INSERT, 20'hABCDE, 1'b0);
    wait_drained();

    run_phase(0, 0, 410, 1'b1);
    run_phase(86, 0, 410, 1'b0);
    run_phase(0, 86, 410, 1'b0);
    run_phase(35, 35, 410, 1'b0);

    spins = 0;
    while ((page_ops_q.size() != 0 || in_valid || victim_status_q.size() != 0) &&
           spins < 200000) begin
      @(negedge clk_i);
      spins++;
    end
    repeat (200) @(negedge clk_i);
    if (victim_status_q.size() != 0)
      flag_mismatch("outstanding outcomes at end, count", 0, victim_status_q.size());
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ecpr_pkg.sv
rtl/core/ecpr_ram.sv
rtl/core/ecpr_ctrl.sv
rtl/core/enhanced_clock_page_replacer.sv
bench/enhanced_clock_page_replacer_test.sv
